>>> rtl/dlts_pkg.sv
// Shared types and constants for the display line timing status block.
package dlts_pkg;

  localparam int HDRAW_CYCLES  = 1006;
  localparam int HBLANK_CYCLES = 226;
  localparam int VISIBLE_LINES = 160;
  localparam int TOTAL_LINES   = 228;

  localparam logic [7:0] VisibleLine = 8'(VISIBLE_LINES);
  localparam logic [7:0] VblankEndLine = 8'(TOTAL_LINES - 1);
  localparam logic [7:0] WrapLine = 8'(TOTAL_LINES);

  localparam logic [31:0] CountdownReset = 32'(HDRAW_CYCLES);
  localparam logic [31:0] ReloadHblankEnd = 32'(HDRAW_CYCLES);
  localparam logic [31:0] ReloadHblankStart = 32'(HBLANK_CYCLES);
  localparam logic [31:0] ReloadFirstEvent = 32'(HBLANK_CYCLES - HDRAW_CYCLES);

  localparam logic [15:0] StWritableMask = 16'hFFF8;
  localparam logic [15:0] StLiveMask = 16'h0007;

  localparam int unsigned StVblank = 0;
  localparam int unsigned StHblank = 1;
  localparam int unsigned StMatch = 2;
  localparam int unsigned StVblankIe = 3;
  localparam int unsigned StHblankIe = 4;
  localparam int unsigned StMatchIe = 5;

  typedef struct packed {
    logic        wr;
    logic [15:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         line_number;
    logic               in_vblank;
    logic               in_hblank;
    logic               line_match;
    logic               hblank_irq;
    logic               vblank_irq;
    logic               irq_line_match;
    logic               hblank_dma_go;
    logic               vblank_dma_go;
    logic               draw_line;
    logic               frame_done;
    logic signed [17:0] cycles_to_event;
  } res_t;

endpackage

>>> rtl/dlts_queue.sv
// Two-entry first-in first-out queue for commands and results.
module dlts_queue #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/dlts_front.sv
// Front end: decodes incoming transactions into commands and queues them.
module dlts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic          opcode_i,
  input  logic [15:0]   cycles_i,
  input  logic [15:0]   write_value_i,
  input  logic          cmd_pop_i,
  output dlts_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o
);
  import dlts_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // keep only the operand the operation uses
  always_comb begin
    cmd_in.wr  = opcode_i;
    cmd_in.arg = opcode_i ? (write_value_i & StWritableMask) : cycles_i;
  end

  dlts_queue #(
    .Width($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .full_o (full),
    .empty_o(cmd_empty)
  );

  assign cmd_valid_o = ~cmd_empty;

endmodule

>>> rtl/dlts_back.sv
// Back end: timing countdown, line counter, status word and result queue.
module dlts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dlts_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  logic           pop,
  output logic           empty,
  output dlts_pkg::res_t res_o
);
  import dlts_pkg::*;

  logic [15:0] st_q, st_d;
  logic [7:0]  line_q, line_d;
  logic [31:0] cd_q, cd_d;
  logic        init_q, init_d;
  logic [31:0] reload;
  logic [31:0] cd_step, cd_evt;
  logic [7:0]  line_inc;
  logic        evt;
  logic        take;
  logic        res_full;
  res_t        res;

  function automatic logic signed [17:0] sat18(logic [31:0] v);
    if (!v[31] && (v[30:17] != '0)) begin
      return 18'sh1FFFF;
    end else if (v[31] && (v[30:17] != '1)) begin
      return 18'sh20000;
    end else begin
      return v[17:0];
    end
  endfunction

  assign take      = cmd_valid_i & ~res_full;
  assign cmd_pop_o = take;

  always_comb begin
    if (st_q[StHblank]) begin
      reload = ReloadHblankEnd;
    end else if (init_q) begin
      reload = ReloadFirstEvent;
    end else begin
      reload = ReloadHblankStart;
    end
    cd_step  = cd_q - 32'(cmd_i.arg);
    cd_evt   = cd_q + reload - 32'(cmd_i.arg);
    evt      = cd_step[31] | (cd_step == '0);
    line_inc = line_q + 8'd1;

    st_d   = st_q;
    line_d = line_q;
    cd_d   = cd_q;
    init_d = init_q;
    res    = '0;

    if (take) begin
      if (cmd_i.wr) begin
        st_d = (st_q & StLiveMask) | (cmd_i.arg & StWritableMask);
      end else if (!evt) begin
        cd_d = cd_step;
      end else begin
        cd_d   = cd_evt;
        init_d = 1'b0;
        if (st_q[StHblank]) begin
          st_d[StHblank] = 1'b0;
          line_d = line_inc;
          if (line_inc == VisibleLine) begin
            st_d[StVblank]    = 1'b1;
            res.frame_done    = 1'b1;
            res.vblank_dma_go = 1'b1;
            res.vblank_irq    = st_q[StVblankIe];
          end else if (line_inc == VblankEndLine) begin
            st_d[StVblank] = 1'b0;
          end else if (line_inc == WrapLine) begin
            line_d = '0;
          end
          if (line_d == st_q[15:8]) begin
            st_d[StMatch]      = 1'b1;
            res.irq_line_match = st_q[StMatchIe];
          end else begin
            st_d[StMatch] = 1'b0;
          end
        end else begin
          st_d[StHblank] = 1'b1;
          if (line_q < VisibleLine) begin
            res.draw_line     = 1'b1;
            res.hblank_dma_go = 1'b1;
          end
          res.hblank_irq = st_q[StHblankIe];
        end
      end
    end

    res.line_number     = line_d;
    res.in_vblank       = st_d[StVblank];
    res.in_hblank       = st_d[StHblank];
    res.line_match      = st_d[StMatch];
    res.cycles_to_event = sat18(cd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      line_q <= '0;
      cd_q   <= CountdownReset;
      init_q <= 1'b1;
    end else begin
      st_q   <= st_d;
      line_q <= line_d;
      cd_q   <= cd_d;
      init_q <= init_d;
    end
  end

  dlts_queue #(
    .Width($bits(res_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take),
    .data_i (res),
    .pop_i  (pop),
    .data_o (res_o),
    .full_o (res_full),
    .empty_o(empty)
  );

endmodule

>>> rtl/display_line_timing_status.sv
// Scanline timing generator with status register for a handheld LCD.
// Each transaction either advances time by a cycle count or writes the status
// register, and yields exactly one result transaction. The block takes one
// transaction per cycle on each side while no queue holds it back (a full
// command queue refuses pushes, a full result queue stalls the core). A
// two-entry command queue feeds the timing core, which computes countdown,
// line counter and status word combinationally per transaction, and a
// two-entry result queue decouples it from the consumer. A result passes
// the command queue, then the result queue, and holds there until popped.
module display_line_timing_status (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic [15:0]        cycles_i,
  input  logic [15:0]        write_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         line_number_o,
  output logic               in_vblank_o,
  output logic               in_hblank_o,
  output logic               line_match_o,
  output logic               hblank_irq_o,
  output logic               vblank_irq_o,
  output logic               irq_line_match_o,
  output logic               hblank_dma_go_o,
  output logic               vblank_dma_go_o,
  output logic               draw_line_o,
  output logic               frame_done_o,
  output logic signed [17:0] cycles_to_event_o
);
  import dlts_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  dlts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .cycles_i     (cycles_i),
    .write_value_i(write_value_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid)
  );

  dlts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign line_number_o     = res.line_number;
  assign in_vblank_o       = res.in_vblank;
  assign in_hblank_o       = res.in_hblank;
  assign line_match_o      = res.line_match;
  assign hblank_irq_o      = res.hblank_irq;
  assign vblank_irq_o      = res.vblank_irq;
  assign irq_line_match_o  = res.irq_line_match;
  assign hblank_dma_go_o   = res.hblank_dma_go;
  assign vblank_dma_go_o   = res.vblank_dma_go;
  assign draw_line_o       = res.draw_line;
  assign frame_done_o      = res.frame_done;
  assign cycles_to_event_o = res.cycles_to_event;

endmodule

>>> rtl/dlts_checker.sv
// Port-level assertions for the display line timing status block.
module dlts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         line_number_o,
  input logic               in_vblank_o,
  input logic               in_hblank_o,
  input logic               line_match_o,
  input logic               hblank_irq_o,
  input logic               vblank_irq_o,
  input logic               irq_line_match_o,
  input logic               hblank_dma_go_o,
  input logic               vblank_dma_go_o,
  input logic               draw_line_o,
  input logic               frame_done_o,
  input logic signed [17:0] cycles_to_event_o
);
  import dlts_pkg::*;

  // hold a waiting result until it is taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(line_number_o)
      && $stable(cycles_to_event_o) && $stable(in_hblank_o))
    else $error("waiting result changed before pop");

  a_vblank_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (vblank_irq_o || frame_done_o) |->
      vblank_dma_go_o && frame_done_o && in_vblank_o && !in_hblank_o
      && !draw_line_o)
    else $error("vblank start flags inconsistent");

  a_hblank_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && draw_line_o |->
      hblank_dma_go_o && in_hblank_o && (line_number_o < VisibleLine)
      && !irq_line_match_o && !vblank_dma_go_o)
    else $error("line draw request outside hblank start");

  a_irq_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (hblank_irq_o || irq_line_match_o) |->
      (hblank_irq_o ? in_hblank_o : line_match_o && !in_hblank_o))
    else $error("interrupt without matching status flag");

endmodule

bind display_line_timing_status dlts_checker u_dlts_checker (.*);
